@@ rtl/bsa_pkg.sv @@
// Shared types and constants for the bitmap slab allocator.
// Used by the top level; the generic RAM has no dependencies.
package bsa_pkg;

  // Field widths of the stream payloads and configuration registers.
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned SIZE_W      = 17;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned OUT_IDX_W   = 10;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned S_TDATA_W   = 48;
  localparam int unsigned M_TDATA_W   = 64;

  // Register values after reset.
  localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 17'd64;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_SIZE  = 2'd1,
    CFG_COUNT = 2'd2
  } cfg_idx_e;

  // Request kinds carried in the input tuser.
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_e;

  // Result status carried in the output tuser.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SUB,
    S_DIV,
    S_CMP,
    S_F_RD,
    S_F_WR,
    S_A_RD,
    S_A_CHK,
    S_A_MUL,
    S_DONE
  } state_e;

endpackage

@@ rtl/bsa_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module bsa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bitmap_slab_allocator_core.sv @@
// Bitmap slab allocator: a free bitmap in RAM, driven by a small sequencer
// around one shared 48-bit adder/subtractor. Depends on bsa_pkg and bsa_ram.
//
// The input is not ready while a request is being worked off. After reset a
// clearing pass writes one bitmap word a cycle, MAP_WORDS words in all (16 at
// the default sizes), before the first request is taken; configuration
// writes are taken at any time. An allocate reads bitmap words one after the
// other, each read in S_A_RD and checked in S_A_CHK, until a free bit below the
// object count turns up or the word base reaches the count, then forms the
// address by shift-and-add of index times size onto the base. A lookup runs a
// restoring division of the address offset, one quotient bit a cycle. A free
// does the same division, then splits the index into word and bit with a shift
// and a mask (WORD_BITS must be a power of two) and does a read-modify-write of
// the bitmap word. A finished result sits in an output register, so the next
// request may be taken while it waits for its transfer.
module bitmap_slab_allocator_core #(
  parameter int unsigned MAX_OBJECTS = 1024,
  parameter int unsigned WORD_BITS   = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bsa_pkg::ADDR_W-1:0]        cfg_data_i,
  // Request stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [bsa_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,  // [47:0] address
  input  logic [bsa_pkg::MODE_W-1:0]        s_axis_tuser_i,  // [1:0] mode
  // Result stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [bsa_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,  // [47:0] object_address,
                                                             // [57:48] object_index, zero pad
  output logic [bsa_pkg::STATUS_W-1:0]      m_axis_tuser_o   // [1:0] status
);

  import bsa_pkg::*;

  localparam int unsigned MAP_WORDS = (MAX_OBJECTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned IDX_W     = $clog2(MAX_OBJECTS);
  localparam int unsigned CNT_W     = $clog2(MAX_OBJECTS + 1);
  localparam int unsigned CW        = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned WB_W      = CNT_W + 1;
  localparam int unsigned BP_W      = $clog2(WORD_BITS);
  localparam int unsigned ITER_W    = $clog2(ADDR_W + 1);

  // Configuration registers.
  logic [ADDR_W-1:0]  base_q;
  logic [SIZE_W-1:0]  size_q;
  logic [COUNT_W-1:0] count_q;

  // Sequencer and datapath registers.
  state_e              state_q, state_d;
  logic [WA_W-1:0]     clr_ptr_q, clr_ptr_d;
  mode_e               mode_q, mode_d;
  logic [ADDR_W-1:0]   dq_q, dq_d;
  logic [SIZE_W-1:0]   rem_q, rem_d;
  logic [SIZE_W-1:0]   div_q, div_d;
  logic [ITER_W-1:0]   iter_q, iter_d;
  logic [WA_W-1:0]     w_q, w_d;
  logic [WB_W-1:0]     wbase_q, wbase_d;
  logic [ADDR_W-1:0]   acc_q, acc_d;
  logic [ADDR_W-1:0]   mcand_q, mcand_d;
  logic [IDX_W-1:0]    mplier_q, mplier_d;
  logic [IDX_W-1:0]    res_idx_q, res_idx_d;
  status_e             res_status_q, res_status_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [ADDR_W-1:0]   out_addr_q, out_addr_d;
  logic [IDX_W-1:0]    out_idx_q, out_idx_d;

  // Derived configuration values.
  logic [SIZE_W-1:0]   size_eff;
  logic [CW-1:0]       cnt_wide;
  logic [CNT_W-1:0]    cnt_eff;

  // Shared adder/subtractor.
  logic [ADDR_W-1:0]   alu_a, alu_b, alu_res;
  logic                alu_sub, alu_co, alu_borrow;

  // Bitmap RAM and word search.
  logic                 ram_we;
  logic [WA_W-1:0]      ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
  logic [WB_W-1:0]      rem_bits;
  logic [WORD_BITS-1:0] word_mask, masked, lowest;
  logic [BP_W-1:0]      low_pos;
  logic [IDX_W-1:0]     found_idx;
  logic [WORD_BITS-1:0] bit_onehot;
  logic [IDX_W+OUT_IDX_W-1:0] out_idx_ext;

  // Effective size and count: a zero size acts as one, the count saturates.
  assign size_eff = (size_q == '0) ? SIZE_W'(1) : size_q;
  assign cnt_wide = CW'(count_q);
  assign cnt_eff  = (cnt_wide > CW'(MAX_OBJECTS)) ? CNT_W'(MAX_OBJECTS) : CNT_W'(cnt_wide);

  // Configuration writes are always accepted.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RESET;
      size_q  <= SIZE_RESET;
      count_q <= COUNT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BASE:  base_q  <= cfg_data_i;
        CFG_SIZE:  size_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_SUB: begin
        alu_a   = dq_q;
        alu_b   = base_q;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = ADDR_W'({rem_q, dq_q[ADDR_W-1]});
        alu_b   = ADDR_W'(div_q);
        alu_sub = 1'b1;
      end
      S_CMP: begin
        alu_a   = dq_q;
        alu_b   = ADDR_W'(cnt_eff);
        alu_sub = 1'b1;
      end
      S_A_MUL: begin
        alu_a   = acc_q;
        alu_b   = mcand_q;
      end
      default: ;
    endcase
  end

  assign {alu_co, alu_res} = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                             + {{ADDR_W{1'b0}}, alu_sub};
  assign alu_borrow = alu_sub & ~alu_co;

  // Search of one bitmap word for the lowest free bit below the count.
  assign rem_bits = WB_W'(cnt_eff) - wbase_q;
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      word_mask[b] = (rem_bits > WB_W'(b));
    end
  end
  assign masked = ram_rdata & word_mask;
  assign lowest = masked & (~masked + WORD_BITS'(1));
  always_comb begin
    low_pos = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (lowest[b]) begin
        low_pos = low_pos | BP_W'(b);
      end
    end
  end
  assign found_idx  = IDX_W'(wbase_q) + IDX_W'(low_pos);
  assign bit_onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << res_idx_q[BP_W-1:0];

  // Sequencer: next state, datapath updates and RAM control.
  always_comb begin
    state_d      = state_q;
    clr_ptr_d    = clr_ptr_q;
    mode_d       = mode_q;
    dq_d         = dq_q;
    rem_d        = rem_q;
    div_d        = div_q;
    iter_d       = iter_q;
    w_d          = w_q;
    wbase_d      = wbase_q;
    acc_d        = acc_q;
    mcand_d      = mcand_q;
    mplier_d     = mplier_q;
    res_idx_d    = res_idx_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_idx_d    = out_idx_q;
    ram_we       = 1'b0;
    ram_waddr    = w_q;
    ram_wdata    = ram_rdata;
    ram_raddr    = w_q;

    // The output register empties on a transfer.
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ptr_q;
        ram_wdata = '1;
        clr_ptr_d = clr_ptr_q + WA_W'(1);
        if (clr_ptr_q == WA_W'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          mode_d       = mode_e'(s_axis_tuser_i);
          dq_d         = s_axis_tdata_i[ADDR_W-1:0];
          rem_d        = '0;
          div_d        = size_eff;
          iter_d       = ITER_W'(ADDR_W);
          w_d          = '0;
          wbase_d      = '0;
          acc_d        = '0;
          res_idx_d    = '0;
          res_status_d = STAT_RANGE;
          case (mode_e'(s_axis_tuser_i))
            MODE_ALLOC:  state_d = S_A_RD;
            MODE_FREE:   state_d = S_SUB;
            MODE_LOOKUP: state_d = S_SUB;
            default:     state_d = S_DONE;
          endcase
        end
      end
      // Offset from the base; an address below the base is out of range.
      S_SUB: begin
        if (alu_borrow) begin
          state_d = S_DONE;
        end else begin
          dq_d    = alu_res;
          rem_d   = '0;
          state_d = S_DIV;
        end
      end
      // One restoring division step: quotient bits enter dq from the bottom.
      S_DIV: begin
        rem_d  = alu_borrow ? {rem_q[SIZE_W-2:0], dq_q[ADDR_W-1]} : alu_res[SIZE_W-1:0];
        dq_d   = {dq_q[ADDR_W-2:0], ~alu_borrow};
        iter_d = iter_q - ITER_W'(1);
        if (iter_q == ITER_W'(1)) begin
          state_d = S_CMP;
        end
      end
      // Index must lie below the count; a free then splits it into word and bit.
      S_CMP: begin
        if (!alu_borrow) begin
          state_d = S_DONE;
        end else begin
          res_idx_d = dq_q[IDX_W-1:0];
          if (mode_q == MODE_LOOKUP) begin
            res_status_d = STAT_OK;
            state_d      = S_DONE;
          end else begin
            state_d = S_F_RD;
          end
        end
      end
      // The upper index bits select the word, the lower ones the bit in it.
      S_F_RD: begin
        ram_raddr = WA_W'(res_idx_q >> BP_W);
        state_d   = S_F_WR;
      end
      S_F_WR: begin
        ram_we       = 1'b1;
        ram_waddr    = WA_W'(res_idx_q >> BP_W);
        ram_wdata    = ram_rdata | bit_onehot;
        res_status_d = STAT_OK;
        state_d      = S_DONE;
      end
      // Allocation scan: stop when the word base reaches the count.
      S_A_RD: begin
        if (wbase_q >= WB_W'(cnt_eff)) begin
          res_status_d = STAT_EMPTY;
          state_d      = S_DONE;
        end else begin
          state_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (masked != '0) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~lowest;
          res_idx_d = found_idx;
          acc_d     = base_q;
          mcand_d   = ADDR_W'(size_eff);
          mplier_d  = found_idx;
          iter_d    = ITER_W'(IDX_W);
          state_d   = S_A_MUL;
        end else begin
          w_d     = w_q + WA_W'(1);
          wbase_d = wbase_q + WB_W'(WORD_BITS);
          state_d = S_A_RD;
        end
      end
      // Shift-and-add of index times size onto the base, modulo 2^48.
      S_A_MUL: begin
        if (mplier_q[0]) begin
          acc_d = alu_res;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        iter_d   = iter_q - ITER_W'(1);
        if (iter_q == ITER_W'(1)) begin
          res_status_d = STAT_OK;
          state_d      = S_DONE;
        end
      end
      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = acc_q;
          out_idx_d    = res_idx_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_ptr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_ptr_q   <= clr_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and payload registers.
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    dq_q         <= dq_d;
    rem_q        <= rem_d;
    div_q        <= div_d;
    iter_q       <= iter_d;
    w_q          <= w_d;
    wbase_q      <= wbase_d;
    acc_q        <= acc_d;
    mcand_q      <= mcand_d;
    mplier_q     <= mplier_d;
    res_idx_q    <= res_idx_d;
    res_status_q <= res_status_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    out_idx_q    <= out_idx_d;
  end

  // Free bitmap, one bit per object, set means free.
  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Ports.
  assign out_idx_ext     = {{OUT_IDX_W{1'b0}}, out_idx_q};
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W-ADDR_W-OUT_IDX_W){1'b0}},
                            out_idx_ext[OUT_IDX_W-1:0], out_addr_q};

  // An error result carries zero address and index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != STAT_OK) |-> (out_addr_q == '0 && out_idx_q == '0))
    else $error("error result with nonzero fields");

  // A successful result names an index below the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STAT_OK) |-> (CNT_W'(out_idx_q) < cnt_eff))
    else $error("result index at or above the object count");

  // Once a request is taken the input stays closed until it is worked off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request taken while another is in progress");

  // The clearing pass never overlaps a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!s_axis_tready_o && !out_valid_q))
    else $error("clearing pass overlaps request handling");

endmodule

@@ test/bitmap_slab_allocator_core_tb.sv @@
// Self-checking testbench for bitmap_slab_allocator_core: directed table, then random phases.
// Holds its own bitmap allocator model; needs bsa_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module bitmap_slab_allocator_core_tb;
  import bsa_pkg::*;

  localparam int unsigned POOL_OBJECTS  = 1024;
  localparam int unsigned MAP_WORD_BITS = 64;
  localparam int unsigned MAP_WORDS     = POOL_OBJECTS / MAP_WORD_BITS;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS   = 75;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_ONES   = '1;

  typedef struct packed {
    status_e               status;
    logic [ADDR_W-1:0]     obj_addr;
    logic [OUT_IDX_W-1:0]  obj_idx;
  } alloc_result_t;

  // One row of the directed table: either a register write or a request.
  typedef struct packed {
    bit                is_reg;
    cfg_idx_e          reg_sel;
    logic [ADDR_W-1:0] value;
    logic [MODE_W-1:0] mode;
    bit                known;
    alloc_result_t     want;
  } step_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [ADDR_W-1:0]       cfg_data_i = '0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [S_TDATA_W-1:0]    s_axis_tdata_i = '0;  // [47:0] address
  logic [MODE_W-1:0]       s_axis_tuser_i = '0;  // [1:0] mode
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0]    m_axis_tdata_o;       // [47:0] object_address, [57:48] object_index
  logic [STATUS_W-1:0]     m_axis_tuser_o;       // [1:0] status

  // Model state: free map (bit set = free) and the three registers.
  logic [MAP_WORD_BITS-1:0] free_map [MAP_WORDS];
  logic [ADDR_W-1:0]        base_q;
  logic [SIZE_W-1:0]        size_q;
  logic [COUNT_W-1:0]       count_q;

  alloc_result_t pending_results [$];
  step_row_t     directed_rows [$];
  int unsigned   send_idle_pct = 33;
  int unsigned   recv_idle_pct = 83;
  int unsigned   errors = 0;

  bitmap_slab_allocator_core #(
    .MAX_OBJECTS(POOL_OBJECTS),
    .WORD_BITS  (MAP_WORD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // A size of zero acts as one.
  function automatic int unsigned eff_stride();
    return (size_q == '0) ? 1 : int'(size_q);
  endfunction

  // Counts above the pool capacity act as the capacity.
  function automatic int unsigned eff_limit();
    return (count_q > POOL_OBJECTS) ? POOL_OBJECTS : int'(count_q);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {16'($urandom()), $urandom()};
  endfunction

  // Computes the result of one request and applies its effect on the free map.
  function automatic alloc_result_t predict_result(logic [MODE_W-1:0] mode,
                                                   logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    int unsigned   stride;
    int unsigned   limit;
    int unsigned   idx;
    logic [ADDR_W-1:0] quot;
    bit            found;
    stride     = eff_stride();
    limit      = eff_limit();
    r.status   = STAT_RANGE;
    r.obj_addr = '0;
    r.obj_idx  = '0;
    found      = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        r.status = STAT_EMPTY;
        // Lowest free index below the count wins; the address wraps at 48 bits.
        for (idx = 0; idx < limit && !found; idx++) begin
          if (free_map[idx / MAP_WORD_BITS][idx % MAP_WORD_BITS]) begin
            found = 1'b1;
            free_map[idx / MAP_WORD_BITS][idx % MAP_WORD_BITS] = 1'b0;
            r.status   = STAT_OK;
            r.obj_idx  = idx[OUT_IDX_W-1:0];
            r.obj_addr = base_q + ADDR_W'(idx) * ADDR_W'(stride);
          end
        end
      end
      MODE_FREE, MODE_LOOKUP: begin
        if (addr >= base_q) begin
          quot = (addr - base_q) / ADDR_W'(stride);
          if (quot < ADDR_W'(limit)) begin
            if (mode == MODE_FREE) begin
              free_map[quot / MAP_WORD_BITS][quot % MAP_WORD_BITS] = 1'b1;
            end
            r.status  = STAT_OK;
            r.obj_idx = quot[OUT_IDX_W-1:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic step_row_t req_row(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr);
    step_row_t row;
    row = '0;
    row.mode  = mode;
    row.value = addr;
    return row;
  endfunction

  function automatic step_row_t req_known(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                                          status_e st, logic [ADDR_W-1:0] oaddr,
                                          logic [OUT_IDX_W-1:0] oidx);
    step_row_t row;
    row = req_row(mode, addr);
    row.known         = 1'b1;
    row.want.status   = st;
    row.want.obj_addr = oaddr;
    row.want.obj_idx  = oidx;
    return row;
  endfunction

  function automatic step_row_t reg_row(cfg_idx_e sel, logic [ADDR_W-1:0] val);
    step_row_t row;
    row = '0;
    row.is_reg  = 1'b1;
    row.reg_sel = sel;
    row.value   = val;
    return row;
  endfunction

  function automatic void check_field(string name, logic [ADDR_W-1:0] want,
                                      logic [ADDR_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Register write transfer; the model register follows at the handshake.
  task automatic write_reg(cfg_idx_e sel, logic [ADDR_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (sel)
      CFG_BASE:  base_q  = val;
      CFG_SIZE:  size_q  = val[SIZE_W-1:0];
      CFG_COUNT: count_q = val[COUNT_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Request transfer with an optional random gap in front of it.
  task automatic send_request(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                              bit known, alloc_result_t want);
    alloc_result_t exp;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= addr;
    s_axis_tuser_i  <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    exp = predict_result(mode, addr);
    pending_results.push_back(known ? want : exp);
  endtask

  // Waits until every expected result has been seen, then lets the block settle.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly allocations and frees of live objects, with lookups and some noise.
  task automatic pick_request(output logic [MODE_W-1:0] mode, output logic [ADDR_W-1:0] addr);
    int unsigned roll;
    int unsigned stride;
    int unsigned limit;
    int unsigned idx;
    int unsigned probe;
    stride = eff_stride();
    limit  = eff_limit();
    roll   = $urandom_range(99);
    mode   = MODE_ALLOC;
    addr   = rand_addr();
    if (roll < 45) begin
      mode = MODE_ALLOC;
    end else if (roll < 88 && limit > 0) begin
      idx = $urandom_range(limit - 1);
      if (roll < 75) begin
        mode = MODE_FREE;
        // Steer toward an object that is currently allocated.
        for (probe = 0; probe < limit && free_map[idx / MAP_WORD_BITS][idx % MAP_WORD_BITS];
             probe++) begin
          idx = (idx + 1) % limit;
        end
      end else begin
        mode = MODE_LOOKUP;
      end
      addr = base_q + ADDR_W'(idx) * ADDR_W'(stride) + ADDR_W'($urandom_range(stride - 1));
    end else begin
      case ($urandom_range(3))
        0: mode = MODE_W'($urandom_range(3));
        1: begin
          mode = $urandom_range(1) ? MODE_FREE : MODE_LOOKUP;
          addr = base_q - ADDR_W'($urandom_range(1, 4096));
        end
        2: begin
          mode = $urandom_range(1) ? MODE_FREE : MODE_LOOKUP;
          addr = base_q + ADDR_W'(limit) * ADDR_W'(stride);
        end
        default: mode = MODE_UNUSED;
      endcase
    end
  endtask

  // Result side: random back-pressure and in-order comparison.
  always @(posedge clk_i) begin : result_check
    alloc_result_t exp;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d addr 0x%0h idx %0d",
                 $time, m_axis_tuser_o, m_axis_tdata_o[47:0], m_axis_tdata_o[57:48]);
      end else begin
        exp = pending_results.pop_front();
        check_field("status", ADDR_W'(exp.status), ADDR_W'(m_axis_tuser_o));
        check_field("object_address", exp.obj_addr, m_axis_tdata_o[47:0]);
        check_field("object_index", ADDR_W'(exp.obj_idx), ADDR_W'(m_axis_tdata_o[57:48]));
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Main stimulus.
  initial begin : stimulus
    step_row_t         row;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] p_base;
    logic [ADDR_W-1:0] p_size;
    logic [ADDR_W-1:0] p_count;
    int                phase;

    for (int w = 0; w < MAP_WORDS; w++) free_map[w] = '1;
    base_q  = BASE_RESET;
    size_q  = SIZE_RESET;
    count_q = COUNT_RESET;

    // Directed table: reset defaults first, then tiny, empty and extreme settings.
    directed_rows.push_back(req_known(MODE_ALLOC, '0, STAT_OK, '0, '0));
    directed_rows.push_back(req_known(MODE_ALLOC, ADDR_ONES, STAT_OK, 48'd64, 10'd1));
    directed_rows.push_back(req_row(MODE_LOOKUP, 48'd127));
    directed_rows.push_back(req_row(MODE_FREE, 48'd64));
    directed_rows.push_back(req_row(MODE_ALLOC, '0));
    directed_rows.push_back(req_row(MODE_FREE, 48'd65472));
    directed_rows.push_back(req_known(MODE_LOOKUP, 48'd65536, STAT_RANGE, '0, '0));
    directed_rows.push_back(req_known(MODE_LOOKUP, ADDR_ONES, STAT_RANGE, '0, '0));
    directed_rows.push_back(req_known(MODE_UNUSED, ADDR_ONES, STAT_RANGE, '0, '0));
    directed_rows.push_back(req_known(MODE_UNUSED, '0, STAT_RANGE, '0, '0));
    directed_rows.push_back(req_row(MODE_FREE, '0));
    directed_rows.push_back(req_row(MODE_ALLOC, '0));
    directed_rows.push_back(req_row(MODE_LOOKUP, '0));
    directed_rows.push_back(reg_row(CFG_BASE, 48'h1000));
    directed_rows.push_back(reg_row(CFG_SIZE, '0));
    directed_rows.push_back(reg_row(CFG_COUNT, 48'd3));
    directed_rows.push_back(req_row(MODE_ALLOC, '0));
    directed_rows.push_back(req_known(MODE_ALLOC, '0, STAT_EMPTY, '0, '0));
    directed_rows.push_back(req_known(MODE_LOOKUP, 48'hFFF, STAT_RANGE, '0, '0));
    directed_rows.push_back(req_row(MODE_LOOKUP, 48'h1002));
    directed_rows.push_back(req_known(MODE_LOOKUP, 48'h1003, STAT_RANGE, '0, '0));
    directed_rows.push_back(req_row(MODE_FREE, 48'h1001));
    directed_rows.push_back(req_row(MODE_ALLOC, '0));
    directed_rows.push_back(reg_row(CFG_COUNT, '0));
    directed_rows.push_back(req_known(MODE_ALLOC, '0, STAT_EMPTY, '0, '0));
    directed_rows.push_back(req_known(MODE_LOOKUP, 48'h1000, STAT_RANGE, '0, '0));
    directed_rows.push_back(reg_row(CFG_BASE, ADDR_ONES));
    directed_rows.push_back(reg_row(CFG_SIZE, 48'h1FFFF));
    directed_rows.push_back(reg_row(CFG_COUNT, 48'd2047));
    // Objects 0 to 2 are taken here, so the next one lands past the wrap.
    directed_rows.push_back(req_known(MODE_ALLOC, '0, STAT_OK, 48'd393212, 10'd3));
    directed_rows.push_back(req_row(MODE_LOOKUP, ADDR_ONES));
    directed_rows.push_back(req_known(MODE_FREE, '0, STAT_RANGE, '0, '0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_reg) begin
        wait_idle();
        write_reg(row.reg_sel, row.value);
      end else begin
        send_request(row.mode, row.value, row.known, row.want);
      end
    end

    // Random phases, each under its own register setting; each pair of phases shares an idle pattern.
    for (phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin send_idle_pct = 33; recv_idle_pct = 83; end
        1: begin send_idle_pct = 83; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (phase)
        0: begin p_base = 48'h0000_1000_0000; p_size = 48'd48;    p_count = 48'd40;   end
        1: begin p_base = rand_addr();        p_size = 48'd65536; p_count = 48'd130;  end
        2: begin p_base = 48'hFFFF_FFFF_8000; p_size = 48'd4096;  p_count = 48'd1024; end
        3: begin p_base = '0;                 p_size = '0;        p_count = 48'd1;    end
        4: begin
          p_base  = rand_addr();
          p_size  = ADDR_W'($urandom_range(1, 65536));
          p_count = ADDR_W'($urandom_range(1, 100));
        end
        default: begin p_base = ADDR_ONES;    p_size = 48'd3;     p_count = 48'd2047; end
      endcase
      wait_idle();
      write_reg(CFG_BASE, p_base);
      write_reg(CFG_SIZE, p_size);
      write_reg(CFG_COUNT, p_count);
      repeat (PHASE_ITEMS) begin
        pick_request(mode, addr);
        send_request(mode, addr, 1'b0, '0);
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bsa_pkg.sv
rtl/bsa_ram.sv
rtl/bitmap_slab_allocator_core.sv
test/bitmap_slab_allocator_core_tb.sv
